// ===== hdl/bta_pkg.sv =====
// Package for the block table allocator: action and status codes, FSM states.
// No dependencies.
package bta_pkg;
    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_USAGE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_ZERO_SIZE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CLR,
        S_DIV,
        S_DONE,
        S_BOOT
    } t_state;

    localparam int unsigned PERMILLE = 1000;
endpackage

// ===== hdl/block_table_allocator.sv =====
// Block table allocator, top level: sequencer plus run table memory.
// Per item: init zeroes the table; allocate scans it from the top, one read a cycle,
// then marks the run (zeroing the table first if not yet initialised); free reads
// the run length, then clears the run; usage scans the table, then one scale step.
// One item at a time; the next transfer is taken the cycle after the result transfer.
// Reset (sync, active low) clears control, then zeroes every table entry.
module block_table_allocator
    import bta_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS  = 1024,
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // action
    input  logic [39:0] s_axis_tdata,  // size_bytes[19:0], free_offset[39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // status[2:0], alloc_offset[18:3],
                                       // usage_permille[28:19], zero pad
);
    localparam int unsigned AW = $clog2(NUM_BLOCKS);
    localparam int unsigned DW = $clog2(NUM_BLOCKS + 1);

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [DW-1:0] w_wdata, w_rdata;
    logic [2:0]    w_status;
    logic [15:0]   w_aoff;
    logic [9:0]    w_perm;

    bta_ctrl #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
               .AW(AW), .DW(DW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tuser), .i_size_bytes(s_axis_tdata[19:0]),
        .i_free_offset(s_axis_tdata[39:20]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_status(w_status), .o_alloc_offset(w_aoff), .o_usage_permille(w_perm),
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_raddr(w_raddr), .i_rdata(w_rdata)
    );

    bta_table #(.DEPTH(NUM_BLOCKS), .AW(AW), .DW(DW)) u_table (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign m_axis_tdata = {3'b000, w_perm, w_aoff, w_status};
endmodule

// ===== hdl/bta_table.sv =====
// Run table memory: one synchronous read port, one write port.
// Depends on nothing but its parameters.
module bta_table #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/bta_ctrl.sv =====
// Sequencer for the block table allocator: clear, scan, mark, free, usage.
// Depends on bta_pkg; drives the run table memory ports.
module bta_ctrl
    import bta_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS  = 1024,
    parameter int unsigned BLOCK_BYTES = 64,
    parameter int unsigned AW          = 10,
    parameter int unsigned DW          = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  logic [19:0]   i_size_bytes,
    input  logic [19:0]   i_free_offset,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_status,
    output logic [15:0]   o_alloc_offset,
    output logic [9:0]    o_usage_permille,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [DW-1:0] o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [DW-1:0] i_rdata
);
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned PW  = CW + 10;
    localparam int unsigned POOL = NUM_BLOCKS * BLOCK_BYTES;
    localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);
    // Reciprocals rounded up; exact floor division over each operand's full range
    localparam int unsigned BSH = 21 + $clog2(BLOCK_BYTES);
    localparam logic [63:0] BRECIP =
        ((64'd1 << BSH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam int unsigned USH = PW + $clog2(NUM_BLOCKS);
    localparam logic [63:0] URECIP =
        ((64'd1 << USH) + 64'(NUM_BLOCKS) - 64'd1) / 64'(NUM_BLOCKS);

    // Byte count to whole blocks, rounded down, by reciprocal multiply
    function automatic logic [20:0] f_blocks(input logic [20:0] x);
        logic [63:0] prod;
        prod = 64'(x) * BRECIP;
        return prod[BSH +: 21];
    endfunction

    t_state  r_state, n_state;
    t_action r_act, n_act;
    logic    r_ready, n_ready;
    logic [CW-1:0] r_idx, n_idx;     // table pointer, also clear counter
    logic [CW-1:0] r_need, n_need;
    logic [CW-1:0] r_found, n_found;
    logic [CW-1:0] r_cnt, n_cnt;     // mark / free counter or used count
    logic          r_rdv, n_rdv;     // read data for r_idx arrives this cycle
    logic [CW-1:0] r_base, n_base;
    logic [PW-1:0] r_num, n_num;     // used count times 1000
    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_status, n_status;
    logic [15:0]   r_aoff, n_aoff;
    logic [9:0]    r_perm, n_perm;
    logic [19:0]   r_size, n_size;

    logic [20:0]   w_need_full;
    logic [63:0]   w_uprod;
    logic [31:0]   w_off;

    assign w_need_full = f_blocks(21'(r_size) + 21'(BLOCK_BYTES - 1));
    assign w_uprod     = 64'(r_num) * URECIP;
    assign w_off       = 32'(r_base) * 32'(BLOCK_BYTES);

    assign o_in_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_status;
    assign o_alloc_offset   = r_aoff;
    assign o_usage_permille = r_perm;

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BOOT;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
        r_act <= n_act; r_need <= n_need; r_found <= n_found;
        r_cnt <= n_cnt; r_rdv <= n_rdv; r_base <= n_base; r_num <= n_num;
        r_status <= n_status; r_aoff <= n_aoff;
        r_perm <= n_perm; r_size <= n_size;
    end

    // Next state and memory control
    always_comb begin
        n_state = r_state; n_act = r_act; n_ready = r_ready; n_idx = r_idx;
        n_need = r_need; n_found = r_found; n_cnt = r_cnt; n_rdv = 1'b0;
        n_base = r_base; n_num = r_num;
        n_ovalid = r_ovalid; n_status = r_status; n_aoff = r_aoff;
        n_perm = r_perm; n_size = r_size;
        o_we = 1'b0; o_waddr = r_idx[AW-1:0]; o_wdata = '0;
        o_raddr = r_idx[AW-1:0];
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        case (r_state)
            S_BOOT: begin
                // Zero every entry once after reset
                o_we = 1'b1; o_wdata = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == NB - 1'b1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_act = t_action'(i_action); n_size = i_size_bytes;
                    n_status = ST_OK; n_aoff = '0; n_perm = '0;
                    n_idx = '0;
                    case (t_action'(i_action))
                        ACT_INIT: n_state = S_CLEAR;
                        ACT_ALLOC: begin
                            if (!r_ready) n_state = S_CLEAR;
                            else if (i_size_bytes == '0) begin
                                n_status = ST_ZERO_SIZE; n_state = S_DONE;
                            end else n_state = S_SCAN;
                        end
                        ACT_FREE: begin
                            if (!r_ready) begin
                                n_status = ST_NOT_READY; n_state = S_CLEAR;
                            end else if (32'(i_free_offset) >= 32'(POOL)) begin
                                n_status = ST_RANGE; n_state = S_DONE;
                            end else n_state = S_FREE_RD;
                        end
                        default: begin
                            n_cnt = '0; n_state = S_SCAN;
                        end
                    endcase
                    if (n_state == S_SCAN && t_action'(i_action) == ACT_ALLOC) begin
                        n_idx = NB - 1'b1; n_found = '0;
                    end
                    if (n_state == S_FREE_RD)
                        n_idx = CW'(f_blocks(21'(i_free_offset)));
                end
            end
            S_CLEAR: begin
                // Sweep zero into every entry
                o_we = 1'b1; o_wdata = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == NB - 1'b1) begin
                    n_ready = 1'b1;
                    if (r_act == ACT_ALLOC) begin
                        if (r_size == '0) begin
                            n_status = ST_ZERO_SIZE; n_state = S_DONE;
                        end else begin
                            n_idx = NB - 1'b1; n_found = '0; n_state = S_SCAN;
                        end
                    end else n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_act == ACT_ALLOC) begin
                    // Issue read at r_idx, evaluate on next cycle
                    n_need = (w_need_full > 21'(NUM_BLOCKS)) ? NB + 1'b1 : CW'(w_need_full);
                    if (!r_rdv) begin
                        n_rdv = 1'b1;
                    end else begin
                        n_found = (i_rdata == '0) ? r_found + 1'b1 : '0;
                        if ((i_rdata == '0) && (r_found + 1'b1 == r_need)) begin
                            n_base = r_idx; n_cnt = '0; n_state = S_MARK;
                        end else if (r_idx == '0) begin
                            n_status = ST_NO_SPACE; n_state = S_DONE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                            o_raddr = n_idx[AW-1:0]; n_rdv = 1'b1;
                        end
                    end
                end else begin
                    // Usage count
                    if (!r_rdv) begin
                        n_rdv = 1'b1;
                    end else begin
                        if (i_rdata != '0) n_cnt = r_cnt + 1'b1;
                        if (r_idx == NB - 1'b1) begin
                            n_num = PW'(n_cnt) * PW'(PERMILLE);
                            n_state = S_DIV;
                        end else begin
                            n_idx = r_idx + 1'b1;
                            o_raddr = n_idx[AW-1:0]; n_rdv = 1'b1;
                        end
                    end
                end
            end
            S_MARK: begin
                o_we = 1'b1; o_waddr = AW'(r_base + r_cnt);
                o_wdata = DW'(r_need);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt + 1'b1 == r_need) begin
                    n_aoff = w_off[15:0]; n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                if (!r_rdv) n_rdv = 1'b1;
                else begin
                    n_need = CW'(i_rdata); n_cnt = '0;
                    n_base = r_idx;
                    n_state = (i_rdata == '0) ? S_DONE : S_FREE_CLR;
                end
            end
            S_FREE_CLR: begin
                o_we = 1'b1; o_waddr = AW'(r_base + r_cnt); o_wdata = '0;
                n_cnt = r_cnt + 1'b1;
                if ((r_cnt + 1'b1 == r_need) || (r_base + r_cnt == NB - 1'b1))
                    n_state = S_DONE;
            end
            S_DIV: begin
                // Scale to per mille: divide by NUM_BLOCKS via reciprocal multiply
                n_perm = w_uprod[USH +: 10]; n_state = S_DONE;
            end
            S_DONE: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hdl/bta_checker.sv =====
// Port checker for the block table allocator, bound to the top level.
// Depends on bta_pkg for status codes.
module bta_checker
    import bta_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // Status code stays in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'(ST_ZERO_SIZE)))
        else $error("status out of range");
    // Permille never exceeds 1000
    a_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:19] <= 10'd1000))
        else $error("usage above 1000");
    // No new item while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");
    // Result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
endmodule

bind block_table_allocator bta_checker u_bta_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
